// File: hdl/mce_pkg.sv
// Package for the Morse character encoder: codes, command and status types,
// the letter pattern table and the ASCII constants used by the decoder.
// No dependencies.
`default_nettype none

package mce_pkg;

    // Field widths.
    localparam int CHAR_W = 8;
    localparam int DOT_W  = 16;
    localparam int DUR_W  = 18;
    localparam int LEN_W  = 3;
    localparam int SYM_N  = 4;
    localparam int IDX_W  = 5;

    // Dot period after reset, in milliseconds.
    localparam logic [DOT_W-1:0] DOT_PERIOD_RESET = 16'd100;

    // ASCII codes that bound the letter ranges, and the space.
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SYM,
        S_OFF,
        S_GAP,
        S_SPACE
    } state_t;

    // Kind of segment the datapath places in the output register.
    typedef enum logic [1:0] {
        SEG_ON,
        SEG_OFF,
        SEG_GAP,
        SEG_SPACE
    } seg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit;
        seg_t kind;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_letter;
        logic is_space;
        logic out_free;
        logic last_sym;
    } sts_t;

    // Morse pattern: symbol count, dash bits with bit 0 sent first.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SYM_N-1:0] dash;
    } pattern_t;

    // International Morse table, indexed by letter number (A is 0).
    function automatic pattern_t letter_pattern(input logic [IDX_W-1:0] idx);
        pattern_t p;
        unique case (idx)
            5'd0:    p = '{len: 3'd2, dash: 4'h2};
            5'd1:    p = '{len: 3'd4, dash: 4'h1};
            5'd2:    p = '{len: 3'd4, dash: 4'h5};
            5'd3:    p = '{len: 3'd3, dash: 4'h1};
            5'd4:    p = '{len: 3'd1, dash: 4'h0};
            5'd5:    p = '{len: 3'd4, dash: 4'h4};
            5'd6:    p = '{len: 3'd3, dash: 4'h3};
            5'd7:    p = '{len: 3'd4, dash: 4'h0};
            5'd8:    p = '{len: 3'd2, dash: 4'h0};
            5'd9:    p = '{len: 3'd4, dash: 4'hE};
            5'd10:   p = '{len: 3'd3, dash: 4'h5};
            5'd11:   p = '{len: 3'd4, dash: 4'h2};
            5'd12:   p = '{len: 3'd2, dash: 4'h3};
            5'd13:   p = '{len: 3'd2, dash: 4'h1};
            5'd14:   p = '{len: 3'd3, dash: 4'h7};
            5'd15:   p = '{len: 3'd4, dash: 4'h6};
            5'd16:   p = '{len: 3'd4, dash: 4'hB};
            5'd17:   p = '{len: 3'd3, dash: 4'h2};
            5'd18:   p = '{len: 3'd3, dash: 4'h0};
            5'd19:   p = '{len: 3'd1, dash: 4'h1};
            5'd20:   p = '{len: 3'd3, dash: 4'h4};
            5'd21:   p = '{len: 3'd4, dash: 4'h8};
            5'd22:   p = '{len: 3'd3, dash: 4'h6};
            5'd23:   p = '{len: 3'd4, dash: 4'h9};
            5'd24:   p = '{len: 3'd4, dash: 4'hD};
            5'd25:   p = '{len: 3'd4, dash: 4'h3};
            default: p = '{len: 3'd1, dash: 4'h0};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mce_channels.sv
// Valid/ready channel interfaces for the Morse character encoder:
// character input, segment output and dot period configuration.
// Depends on mce_pkg for the field widths.
`default_nettype none

interface mce_char_if;
    logic                        valid;
    logic                        ready;
    logic [mce_pkg::CHAR_W-1:0]  character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface mce_seg_if;
    logic                        valid;
    logic                        ready;
    logic                        led_on;
    logic [mce_pkg::DUR_W-1:0]   duration_ms;
    logic                        last;

    modport source (output valid, output led_on, output duration_ms, output last,
                    input ready);
    modport sink   (input valid, input led_on, input duration_ms, input last,
                    output ready);
endinterface

interface mce_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mce_pkg::DOT_W-1:0]   dot_ms;

    modport source (output valid, output dot_ms, input ready);
    modport sink   (input valid, input dot_ms, output ready);
endinterface

`default_nettype wire

// File: hdl/mce_ctrl.sv
// Controller state machine of the Morse character encoder: steps through the
// symbols of a letter and issues emit commands to the datapath.
// Depends on mce_pkg for the state, command and status types.
`default_nettype none

module mce_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mce_pkg::sts_t  sts,
    output mce_pkg::cmd_t       cmd
);

    mce_pkg::state_t state_reg;
    mce_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mce_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. Each emitting state waits for a free output register.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '{load: 1'b0, emit: 1'b0, kind: mce_pkg::SEG_ON};
        in_ready   = 1'b0;
        unique case (state_reg)
            mce_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.is_letter)
                    begin
                        cmd.load   = 1'b1;
                        state_next = mce_pkg::S_SYM;
                    end
                    else if (sts.is_space)
                    begin
                        state_next = mce_pkg::S_SPACE;
                    end
                end
            end
            mce_pkg::S_SYM:
            begin
                cmd.kind = mce_pkg::SEG_ON;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mce_pkg::S_OFF;
                end
            end
            mce_pkg::S_OFF:
            begin
                cmd.kind = mce_pkg::SEG_OFF;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last_sym ? mce_pkg::S_GAP : mce_pkg::S_SYM;
                end
            end
            mce_pkg::S_GAP:
            begin
                cmd.kind = mce_pkg::SEG_GAP;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mce_pkg::S_IDLE;
                end
            end
            mce_pkg::S_SPACE:
            begin
                cmd.kind = mce_pkg::SEG_SPACE;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mce_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mce_pkg::S_IDLE;
            end
        endcase
    end

    // A segment is only placed in a register that is empty or being drained.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emit issued while output register is held");

    // A new pattern is loaded only when a character transaction is taken.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == mce_pkg::S_IDLE) && in_valid && in_ready)
        else $error("pattern loaded outside an input transaction");

    // The off segment after the final symbol leads to the closing gap.
    a_off_to_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mce_pkg::S_OFF) && cmd.emit && sts.last_sym
        |=> state_reg == mce_pkg::S_GAP)
        else $error("final symbol not followed by the letter gap");

    // The closing segment of a character returns the controller to idle.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && ((cmd.kind == mce_pkg::SEG_GAP) || (cmd.kind == mce_pkg::SEG_SPACE))
        |=> state_reg == mce_pkg::S_IDLE)
        else $error("controller not idle after the last segment");

endmodule

`default_nettype wire

// File: hdl/mce_dp.sv
// Datapath of the Morse character encoder: character decode and pattern lookup,
// symbol shift register, dot period register and the output segment register.
// Depends on mce_pkg for types, constants and the letter table.
`default_nettype none

module mce_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [mce_pkg::CHAR_W-1:0]  character,
    input  wire logic                        cfg_we,
    input  wire logic [mce_pkg::DOT_W-1:0]   cfg_data,
    input  wire mce_pkg::cmd_t               cmd,
    output mce_pkg::sts_t                    sts,
    input  wire logic                        seg_ready,
    output logic                             seg_valid,
    output logic                             led_on,
    output logic [mce_pkg::DUR_W-1:0]        duration_ms,
    output logic                             last
);

    logic [mce_pkg::DOT_W-1:0]  dot_reg;
    logic [mce_pkg::LEN_W-1:0]  cnt_reg;
    logic [mce_pkg::LEN_W-1:0]  cnt_next;
    logic [mce_pkg::SYM_N-1:0]  dash_reg;
    logic [mce_pkg::SYM_N-1:0]  dash_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       led_reg;
    logic [mce_pkg::DUR_W-1:0]  dur_reg;
    logic                       last_reg;
    logic                       is_upper;
    logic                       is_lower;
    logic [mce_pkg::IDX_W-1:0]  idx;
    mce_pkg::pattern_t          pat;
    logic [mce_pkg::DUR_W-1:0]  dot_ext;
    logic [mce_pkg::DUR_W-1:0]  dur_sel;
    logic                       led_sel;
    logic                       last_sel;

    // Character decode and table lookup.
    always_comb
    begin
        is_upper = (character >= mce_pkg::ASCII_UPPER_A) &&
                   (character <= mce_pkg::ASCII_UPPER_Z);
        is_lower = (character >= mce_pkg::ASCII_LOWER_A) &&
                   (character <= mce_pkg::ASCII_LOWER_Z);
        if (is_lower)
        begin
            idx = mce_pkg::IDX_W'(character - mce_pkg::ASCII_LOWER_A);
        end
        else
        begin
            idx = mce_pkg::IDX_W'(character - mce_pkg::ASCII_UPPER_A);
        end
        pat = mce_pkg::letter_pattern(idx);
    end

    // Segment level, length and end mark for the commanded kind.
    always_comb
    begin
        dot_ext = {{(mce_pkg::DUR_W - mce_pkg::DOT_W){1'b0}}, dot_reg};
        unique case (cmd.kind)
            mce_pkg::SEG_ON:
            begin
                led_sel  = 1'b1;
                last_sel = 1'b0;
                dur_sel  = dash_reg[0] ? (dot_ext + (dot_ext << 1)) : dot_ext;
            end
            mce_pkg::SEG_OFF:
            begin
                led_sel  = 1'b0;
                last_sel = 1'b0;
                dur_sel  = dot_ext;
            end
            mce_pkg::SEG_GAP:
            begin
                led_sel  = 1'b0;
                last_sel = 1'b1;
                dur_sel  = dot_ext << 1;
            end
            mce_pkg::SEG_SPACE:
            begin
                led_sel  = 1'b0;
                last_sel = 1'b1;
                dur_sel  = dot_ext << 2;
            end
            default:
            begin
                led_sel  = 1'b0;
                last_sel = 1'b0;
                dur_sel  = '0;
            end
        endcase
    end

    // Symbol counter and dash shift register: loaded with a new pattern, and advanced after each off segment.
    always_comb
    begin
        cnt_next  = cnt_reg;
        dash_next = dash_reg;
        if (cmd.load)
        begin
            cnt_next  = pat.len;
            dash_next = pat.dash;
        end
        else if (cmd.emit && (cmd.kind == mce_pkg::SEG_OFF))
        begin
            cnt_next  = cnt_reg - 1'b1;
            dash_next = dash_reg >> 1;
        end
    end

    // Output register is held until the sink takes the transaction.
    always_comb
    begin
        if (cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else if (seg_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= mce_pkg::DOT_PERIOD_RESET;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dot_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dash_reg <= dash_next;
        if (cmd.emit)
        begin
            led_reg  <= led_sel;
            dur_reg  <= dur_sel;
            last_reg <= last_sel;
        end
    end

    // Status to the controller.
    always_comb
    begin
        sts.is_letter = is_upper || is_lower;
        sts.is_space  = (character == mce_pkg::ASCII_SPACE);
        sts.out_free  = !valid_reg || seg_ready;
        sts.last_sym  = (cnt_reg == mce_pkg::LEN_W'(1));
    end

    assign seg_valid   = valid_reg;
    assign led_on      = led_reg;
    assign duration_ms = dur_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// File: hdl/morse_character_encoder.sv
// Morse character encoder top level: one character per input transaction,
// one LED segment per output transaction, controller and datapath joined here.
// A new character is taken only while idle, once every segment of the previous one
// has been emitted; a letter of n symbols gives 2n+1 segments, a space one, and other
// characters none; one segment is emitted per cycle while the output register is free.
// Reset (rst_n, async low): idle, output empty, dot period 100 ms.
`default_nettype none

module morse_character_encoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mce_char_if.sink    chr,
    mce_seg_if.source   seg,
    mce_cfg_if.sink     cfg
);

    mce_pkg::cmd_t  cmd;
    mce_pkg::sts_t  sts;
    logic           in_ready;

    assign chr.ready = in_ready;
    assign cfg.ready = 1'b1;

    // Controller.
    mce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chr.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    mce_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .character   (chr.character),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.dot_ms),
        .cmd         (cmd),
        .sts         (sts),
        .seg_ready   (seg.ready),
        .seg_valid   (seg.valid),
        .led_on      (seg.led_on),
        .duration_ms (seg.duration_ms),
        .last        (seg.last)
    );

endmodule

`default_nettype wire
